// ===== design/bdil_pkg.sv =====
package bdil_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W     = 11;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;

  // result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_LW    = $clog2(RES_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic               pix;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               eof;
  } result_t;

  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } push_t;

endpackage

// ===== design/bdil_cfg.sv =====
module bdil_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdil_pkg::APB_AW-1:0]  paddr,
  input  logic [bdil_pkg::APB_DW-1:0]  pwdata,
  output logic [bdil_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output bdil_pkg::cfg_t               cfg
);
  import bdil_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= CFG_W'(DEF_MAX_WIDTH);
      cfg.height <= CFG_W'(DEF_MAX_HEIGHT);
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg.width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = APB_DW'(cfg.width);
      REG_HEIGHT: prdata = APB_DW'(cfg.height);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== design/bdil_window.sv =====
module bdil_window #(
  parameter int MAX_WIDTH  = bdil_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bdil_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdil_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdil_pkg::PIX_W-1:0]   pixel_value,
  input  logic [bdil_pkg::RES_LW-1:0]  res_level,
  output bdil_pkg::push_t              push
);
  import bdil_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int CMPWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CMPWH = (RW > CFG_W) ? RW : CFG_W;
  localparam int SUMW  = RES_LW + 1;

  // line store: bit 1 holds row y-2, bit 0 holds row y-1
  logic [1:0] line_mem [MAX_WIDTH];

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [8:0]    win;

  logic          s1_valid;
  logic [CW-1:0] s1_x;
  logic [RW-1:0] s1_y;
  logic          s1_last;
  logic          s1_flush;
  logic          s1_cur;
  logic [1:0]    rd_q;
  logic          fwd_hit;
  logic [1:0]    fwd_data;

  logic [WW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [CMPWW-1:0] w_wide;
  logic [CMPWH-1:0] h_wide;
  logic [CW-1:0]    x0;
  logic [RW-1:0]    y0;
  logic             last0;
  logic             flush0;
  logic             cur0;
  logic             acc;
  logic [SUMW-1:0]  pending;

  logic [1:0] rd;
  logic       lower;
  logic       upper;
  logic [1:0] wr_data;
  logic [8:0] win_next;
  logic       has_rows;
  logic [RW-1:0] r;

  always_comb begin
    w_wide = CMPWW'(cfg.width);
    h_wide = CMPWH'(cfg.height);
    if (w_wide == '0)
      w_eff = WW'(1);
    else if (w_wide > CMPWW'(MAX_WIDTH))
      w_eff = WW'(MAX_WIDTH);
    else
      w_eff = WW'(w_wide);
    if (h_wide == '0)
      h_eff = RW'(1);
    else if (h_wide > CMPWH'(MAX_HEIGHT))
      h_eff = RW'(MAX_HEIGHT);
    else
      h_eff = RW'(h_wide);
  end

  // clamp counters left past the end by a register change
  always_comb begin
    if (WW'(col_cnt) >= w_eff)
      x0 = CW'(w_eff - WW'(1));
    else
      x0 = col_cnt;
    last0  = (WW'(x0) == w_eff - WW'(1));
    flush0 = (row_cnt >= h_eff);
    y0     = flush0 ? h_eff : row_cnt;
    cur0   = !flush0 && (pixel_value != '0);
  end

  // room for the item in flight and this one, two results each at most
  assign pending  = SUMW'(res_level) + (s1_valid ? SUMW'(2) : SUMW'(0)) + SUMW'(2);
  assign in_ready = (pending <= SUMW'(RES_DEPTH));
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
      win      <= '0;
    end else begin
      s1_valid <= acc;
      if (acc) begin
        if (last0) begin
          col_cnt <= '0;
          row_cnt <= flush0 ? '0 : y0 + RW'(1);
        end else begin
          col_cnt <= x0 + CW'(1);
          row_cnt <= y0;
        end
      end
      if (s1_valid)
        win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x     <= x0;
      s1_y     <= y0;
      s1_last  <= last0;
      s1_flush <= flush0;
      s1_cur   <= cur0;
      rd_q     <= line_mem[x0];
      // the write below lands after this read: take it from the write port
      fwd_hit  <= s1_valid && (s1_x == x0);
      fwd_data <= wr_data;
    end
    if (s1_valid)
      line_mem[s1_x] <= wr_data;
  end

  always_comb begin
    rd       = fwd_hit ? fwd_data : rd_q;
    lower    = (s1_y != '0) ? rd[0] : 1'b0;
    upper    = (s1_y > RW'(1)) ? rd[1] : 1'b0;
    wr_data  = {lower, s1_cur};
    if (s1_x == '0)
      win_next = {6'b0, upper, lower, s1_cur};
    else
      win_next = {win[5:0], upper, lower, s1_cur};
    has_rows = (s1_y != '0);
    r        = s1_y - RW'(1);

    push.a_valid = s1_valid && has_rows && (s1_x != '0);
    push.a.pix   = |win_next;
    push.a.col   = COORD_W'(s1_x - CW'(1));
    push.a.row   = COORD_W'(r);
    push.a.last  = !s1_last;
    push.a.eof   = 1'b0;

    // right edge: column beyond the image reads as zero
    push.b_valid = s1_valid && has_rows && s1_last;
    push.b.pix   = |win_next[5:0];
    push.b.col   = COORD_W'(s1_x);
    push.b.row   = COORD_W'(r);
    push.b.last  = 1'b1;
    push.b.eof   = s1_flush;
  end

endmodule

// ===== design/bdil_out_fifo.sv =====
module bdil_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  bdil_pkg::push_t              push,
  output logic [bdil_pkg::RES_LW-1:0]  level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bdil_pkg::result_t            head
);
  import bdil_pkg::*;

  result_t           q [RES_DEPTH];
  logic [RES_AW-1:0] wp;
  logic [RES_AW-1:0] rp;
  logic [1:0]        n_push;
  logic              pop;
  result_t           first;

  assign n_push    = 2'(push.a_valid) + 2'(push.b_valid);
  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign first     = push.a_valid ? push.a : push.b;
  assign head      = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + RES_AW'(n_push);
      if (pop)
        rp <= rp + RES_AW'(1);
      level <= level + RES_LW'(n_push) - RES_LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_valid || push.b_valid)
      q[wp] <= first;
    if (push.a_valid && push.b_valid)
      q[wp + RES_AW'(1)] <= push.b;
  end

endmodule

// ===== design/binary_dilation_3x3.sv =====
// Streaming 3x3 binary dilation. Pixels enter in raster order, one item per
// clock; a nonzero byte counts as set and everything outside the image reads
// as zero. Results lag one row and one column: the item at (x,y) yields the
// result for (x-1,y-1), and the last item of a row also yields (width-1,y-1),
// so row 0 yields nothing and one flush row of width items (values ignored)
// must follow each image. Each item makes one read and one write of a single
// 2-bit-wide line store per pixel, with write-to-read forwarding for width 1.
// Results are taken from the registered item and pass through an 8-entry
// queue; input ready drops only while that queue cannot take two more items'
// results. The line store needs no clearing after reset. Registers: width at
// 0x0, height at 0x4 (11 bits each, 0 acts as 1, oversize is clamped); write
// them only while the block is idle.
module binary_dilation_3x3 #(
  parameter int MAX_WIDTH  = bdil_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bdil_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdil_pkg::APB_AW-1:0]   paddr,
  input  logic [bdil_pkg::APB_DW-1:0]   pwdata,
  output logic [bdil_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdil_pkg::PIX_W-1:0]    pixel_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_pixel,
  output logic [bdil_pkg::COORD_W-1:0]  out_col,
  output logic [bdil_pkg::COORD_W-1:0]  out_row,
  output logic                          last_in_run,
  output logic                          end_of_frame
);
  import bdil_pkg::*;

  cfg_t              cfg;
  push_t             push;
  logic [RES_LW-1:0] res_level;
  result_t           head;

  bdil_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdil_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .res_level   (res_level),
    .push        (push)
  );

  bdil_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .level     (res_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_pixel = head.pix;
  assign out_col      = head.col;
  assign out_row      = head.row;
  assign last_in_run  = head.last;
  assign end_of_frame = head.eof;

endmodule

// ===== tb/tb_binary_dilation_3x3.sv =====
`timescale 1ns / 100ps

module tb_binary_dilation_3x3;
  import bdil_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int SCRIPT_LEN    = 23;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    reg_idx_t         ridx;
    logic [CFG_W-1:0] value;
    logic             typed;
    logic [1:0]       n_exp;
    logic             exp_pix;
    logic             exp_eof;
  } script_row_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [PIX_W-1:0]    pixel_value = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic                result_pixel;
  logic [COORD_W-1:0]  out_col;
  logic [COORD_W-1:0]  out_row;
  logic                last_in_run;
  logic                end_of_frame;

  // tags that travel with the item being offered
  logic       tag_typed = 1'b0;
  logic [1:0] tag_n     = '0;
  logic       tag_pix   = 1'b0;
  logic       tag_eof   = 1'b0;

  logic steady = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // shadow of the block's registers and state
  logic [CFG_W-1:0] width_reg  = CFG_W'(1024);
  logic [CFG_W-1:0] height_reg = CFG_W'(1024);
  logic             row_y1 [MAX_W] = '{default: 1'b0};
  logic             row_y2 [MAX_W] = '{default: 1'b0};
  logic [8:0]       window  = '0;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  result_t          dilated_q [$];
  result_t          last_dilated;

  script_row_t script [SCRIPT_LEN] = '{
    // one-pixel image, width and height written as zero
    '{ROW_REG,   REG_WIDTH,  11'd0,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_REG,   REG_HEIGHT, 11'd0,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h080, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h0FF, 1'b1, 2'd1, 1'b1, 1'b1},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h0FF, 1'b1, 2'd1, 1'b0, 1'b1},
    '{ROW_PIXEL, REG_WIDTH,  11'h001, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b1, 2'd1, 1'b1, 1'b1},
    // 4x3 image, shrunk to width 2 in row 1, then cut short to height 1
    '{ROW_REG,   REG_WIDTH,  11'd4,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_REG,   REG_HEIGHT, 11'd3,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h040, 1'b1, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h002, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_REG,   REG_WIDTH,  11'd2,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h000, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_REG,   REG_HEIGHT, 11'd1,   1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h0FF, 1'b0, 2'd0, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_WIDTH,  11'h0FF, 1'b0, 2'd0, 1'b0, 1'b0}
  };

  binary_dilation_3x3 dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_pixel (result_pixel),
    .out_col      (out_col),
    .out_row      (out_row),
    .last_in_run  (last_in_run),
    .end_of_frame (end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // Advance the shadow by one pixel and queue the dilated pixels it releases.
  function automatic int dilate_step(input logic [PIX_W-1:0] px);
    int unsigned w, h, x, y;
    logic        flush, last_col, cur_bit, mid_bit, top_bit;
    result_t     r;
    int          n;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    x = col_pos;
    y = row_pos;
    n = 0;
    flush = (y >= h);
    if (x >= w) x = w - 1;
    last_col = (x == w - 1);
    if (flush) y = h;
    cur_bit = !flush && (px != '0);
    mid_bit = (y >= 1) ? row_y1[x] : 1'b0;
    top_bit = (y >= 2) ? row_y2[x] : 1'b0;
    row_y2[x] = mid_bit;
    row_y1[x] = cur_bit;
    if (x == 0) window = {6'b0, top_bit, mid_bit, cur_bit};
    else        window = {window[5:0], top_bit, mid_bit, cur_bit};
    if (y >= 1) begin
      if (x >= 1) begin
        r.pix  = |window;
        r.col  = COORD_W'(x - 1);
        r.row  = COORD_W'(y - 1);
        r.last = !last_col;
        r.eof  = 1'b0;
        dilated_q.push_back(r);
        last_dilated = r;
        n++;
      end
      // column past the right edge reads as zero
      if (last_col) begin
        r.pix  = |window[5:0];
        r.col  = COORD_W'(w - 1);
        r.row  = COORD_W'(y - 1);
        r.last = 1'b1;
        r.eof  = (y - 1 == h - 1);
        dilated_q.push_back(r);
        last_dilated = r;
        n++;
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = flush ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    return n;
  endfunction

  task automatic flag_field(input string name, input int want, input int got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    int n;
    if (!rst && in_valid && in_ready) begin
      n = dilate_step(pixel_value);
      if (tag_typed) begin
        flag_field("result count", tag_n, n);
        if (n > 0 && n == tag_n) begin
          flag_field("tabled result_pixel", tag_pix, last_dilated.pix);
          flag_field("tabled end_of_frame", tag_eof, last_dilated.eof);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (dilated_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual col %0d row %0d pix %0b",
                 $time, out_col, out_row, result_pixel);
      end else begin
        want = dilated_q.pop_front();
        flag_field("result_pixel", want.pix, result_pixel);
        flag_field("out_col", want.col, out_col);
        flag_field("out_row", want.row, out_row);
        flag_field("last_in_run", want.last, last_in_run);
        flag_field("end_of_frame", want.eof, end_of_frame);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_binary_dilation_3x3 NOT OK");
      $finish;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] v, input logic typed,
                            input logic [1:0] n, input logic ep, input logic ee);
    pixel_value <= v;
    in_valid    <= 1'b1;
    tag_typed   <= typed;
    tag_n       <= n;
    tag_pix     <= ep;
    tag_eof     <= ee;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_idle();
    int gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < 28) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every queued result has come out, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (dilated_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else                  height_reg = v;
  endtask

  initial begin
    script_row_t row;
    int          taken, frame, fw, fh, set_pct;
    logic [CFG_W-1:0] wv, hv;
    logic [PIX_W-1:0] v;
    taken = 0;
    frame = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.ridx, row.value);
      end else begin
        maybe_idle();
        push_pixel(row.value[PIX_W-1:0], row.typed, row.n_exp, row.exp_pix, row.exp_eof);
      end
    end

    while (taken < RANDOM_ITEMS) begin
      if (frame == 7) begin
        // tallest image, one column wide
        wv = '0; hv = CFG_W'(2047); fw = 1; fh = MAX_H;
      end else begin
        fw = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        fh = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
        wv = (fw == 1 && $urandom_range(1) == 1) ? '0 : CFG_W'(fw);
        hv = (fh == 1 && $urandom_range(1) == 1) ? '0 : CFG_W'(fh);
      end
      write_reg(REG_WIDTH, wv);
      write_reg(REG_HEIGHT, hv);
      case ($urandom_range(3))
        0:       set_pct = 5;
        1:       set_pct = 25;
        2:       set_pct = 60;
        default: set_pct = 95;
      endcase
      // rows 0..fh-1 are the image, row fh is the flush row
      for (int y = 0; y <= fh; y++) begin
        for (int x = 0; x < fw; x++) begin
          steady <= (taken >= 500 && taken < 900);
          if (frame == 4 && y == 1 && x == 0) drain();
          if (y == fh) v = PIX_W'($urandom_range(255));
          else v = ($urandom_range(99) < set_pct) ? PIX_W'($urandom_range(255, 1)) : '0;
          maybe_idle();
          push_pixel(v, 1'b0, 2'd0, 1'b0, 1'b0);
          taken++;
        end
      end
      frame++;
    end

    drain();
    if (mismatches == 0) $display("tb_binary_dilation_3x3 OK");
    else $display("tb_binary_dilation_3x3 NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bdil_pkg.sv
design/bdil_cfg.sv
design/bdil_window.sv
design/bdil_out_fifo.sv
design/binary_dilation_3x3.sv
tb/tb_binary_dilation_3x3.sv
